FILE: design/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for clocked concurrent assertions with asynchronous reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// The expression must never be true at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error(msg);

`endif

FILE: design/cslc_pkg.sv
// ---------------------------------------------------------------------------
// cslc_pkg
// Types, character codes and keyword tables for the C source line classifier.
// ---------------------------------------------------------------------------
package cslc_pkg;

	localparam int LINE_NUM_WIDTH = 24;
	localparam int NUM_KEYWORDS   = 6;
	localparam int KW_SLOTS       = 8;

	typedef logic [2:0] kw_idx_t;
	typedef logic [2:0] kw_cnt_t;
	typedef logic [2:0] scan_mode_t;

	localparam scan_mode_t MODE_NORMAL = 3'd0;
	localparam scan_mode_t MODE_DQUOTE = 3'd1;
	localparam scan_mode_t MODE_SQUOTE = 3'd2;
	localparam scan_mode_t MODE_BLOCK  = 3'd3;
	localparam scan_mode_t MODE_LINE   = 3'd4;

	localparam logic [7:0] CH_NEWLINE   = 8'h0A;
	localparam logic [7:0] CH_DQUOTE    = 8'h22;
	localparam logic [7:0] CH_SQUOTE    = 8'h27;
	localparam logic [7:0] CH_STAR      = 8'h2A;
	localparam logic [7:0] CH_SLASH     = 8'h2F;
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;

	typedef struct packed {
		logic       kind;
		logic [7:0] byte_value;
	} src_item_t;

	typedef struct packed {
		logic [LINE_NUM_WIDTH-1:0] line_num;
		logic                      numbered;
	} res_item_t;

	typedef struct packed {
		logic      emit;
		res_item_t item;
	} scan_out_t;

	typedef struct packed {
		logic    hit;
		kw_idx_t idx;
	} kw_hit_t;

	typedef logic [7:0] kw_text_t [KW_SLOTS][KW_SLOTS];
	typedef logic [2:0] kw_len_t [KW_SLOTS];
	typedef logic [2:0] kw_lcp_t [KW_SLOTS][KW_SLOTS];

	// Skipped keywords: else, break, do, enum, struct, union.
	localparam kw_text_t KW_CHAR = '{
		'{"e", "l", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"b", "r", "e", "a", "k", 8'h00, 8'h00, 8'h00},
		'{"d", "o", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"e", "n", "u", "m", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"s", "t", "r", "u", "c", "t", 8'h00, 8'h00},
		'{"u", "n", "i", "o", "n", 8'h00, 8'h00, 8'h00},
		'{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
	};

	localparam kw_len_t KW_LEN = '{3'd4, 3'd5, 3'd2, 3'd4, 3'd6, 3'd5, 3'd0, 3'd0};

	// Length of the common prefix of each pair of keywords.
	localparam kw_lcp_t KW_LCP = '{
		'{3'd4, 3'd0, 3'd0, 3'd1, 3'd0, 3'd0, 3'd0, 3'd0},
		'{3'd0, 3'd5, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
		'{3'd0, 3'd0, 3'd2, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
		'{3'd1, 3'd0, 3'd0, 3'd4, 3'd0, 3'd0, 3'd0, 3'd0},
		'{3'd0, 3'd0, 3'd0, 3'd0, 3'd6, 3'd0, 3'd0, 3'd0},
		'{3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd5, 3'd0, 3'd0},
		'{3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
		'{3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0}
	};

	// First keyword in table order that shares the first count letters with
	// keyword base and continues with byte c.
	function automatic kw_hit_t kw_extend(kw_idx_t base, kw_cnt_t count, logic [7:0] c);
		kw_hit_t r;
		r = '0;
		for (int k = NUM_KEYWORDS - 1; k >= 0; k--) begin
			if (KW_LEN[k] > count && KW_LCP[base][k] >= count && KW_CHAR[k][count] == c) begin
				r.hit = 1'b1;
				r.idx = kw_idx_t'(k);
			end
		end
		return r;
	endfunction

	function automatic logic is_alnum(logic [7:0] c);
		return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
			(c >= "a" && c <= "z");
	endfunction

endpackage

FILE: design/cslc_scan.sv
// ---------------------------------------------------------------------------
// cslc_scan
// Lexer state and per-byte next-state logic; produces one line result at a
// newline or at a flush that follows a non-empty partial line.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module cslc_scan import cslc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      step,
	input  src_item_t item,
	output scan_out_t result
);

	scan_mode_t                mode_q, n_mode;
	logic                      pending_q, n_pending;
	kw_idx_t                   kw_idx_q, n_kw_idx;
	kw_cnt_t                   kw_cnt_q, n_kw_cnt;
	logic                      bs_par_q, n_bs_par;
	logic                      flag_q, n_flag;
	logic                      has_bytes_q, n_has_bytes;
	logic [LINE_NUM_WIDTH-1:0] count_q, n_count;
	logic [LINE_NUM_WIDTH-1:0] count_inc;
	logic [7:0]                c;
	kw_hit_t                   ext_hit;
	kw_hit_t                   first_hit;
	kw_cnt_t                   ext_cnt;

	assign c         = item.byte_value;
	assign count_inc = (count_q == '1) ? count_q : count_q + 1'b1;
	assign ext_hit   = kw_extend(kw_idx_q, kw_cnt_q, c);
	assign first_hit = kw_extend('0, '0, c);
	assign ext_cnt   = kw_cnt_t'(kw_cnt_q + 3'd1);

	always_comb begin
		logic do_normal;
		n_mode      = mode_q;
		n_pending   = pending_q;
		n_kw_idx    = kw_idx_q;
		n_kw_cnt    = kw_cnt_q;
		n_bs_par    = bs_par_q;
		n_flag      = flag_q;
		n_has_bytes = has_bytes_q;
		n_count     = count_q;
		do_normal   = 1'b0;
		result      = '0;
		result.item.line_num = count_inc;
		if (item.kind) begin
			result.emit          = has_bytes_q;
			result.item.numbered = flag_q | (kw_cnt_q != '0);
			n_mode      = MODE_NORMAL;
			n_pending   = 1'b0;
			n_kw_idx    = '0;
			n_kw_cnt    = '0;
			n_bs_par    = 1'b0;
			n_flag      = 1'b0;
			n_has_bytes = 1'b0;
			n_count     = '0;
		end else begin
			n_has_bytes = 1'b1;
			n_bs_par    = (c == CH_BACKSLASH) ? ~bs_par_q : 1'b0;
			case (mode_q)
				MODE_DQUOTE: begin
					if (c == CH_DQUOTE && !bs_par_q)
						n_mode = MODE_NORMAL;
				end
				MODE_SQUOTE: begin
					if (c == CH_SQUOTE && !bs_par_q)
						n_mode = MODE_NORMAL;
				end
				MODE_BLOCK: begin
					if (pending_q && c == CH_SLASH) begin
						n_mode    = MODE_NORMAL;
						n_pending = 1'b0;
					end else begin
						n_pending = (c == CH_STAR);
					end
				end
				MODE_LINE: begin
					if (c == CH_NEWLINE)
						n_mode = MODE_NORMAL;
				end
				default: begin
					if (pending_q) begin
						n_pending = 1'b0;
						if (c == CH_STAR)
							n_mode = MODE_BLOCK;
						else if (c == CH_SLASH)
							n_mode = MODE_LINE;
						else
							do_normal = 1'b1;
					end else if (kw_cnt_q != '0) begin
						if (ext_hit.hit) begin
							if (ext_cnt >= KW_LEN[ext_hit.idx]) begin
								n_kw_cnt = '0;
							end else begin
								n_kw_idx = ext_hit.idx;
								n_kw_cnt = ext_cnt;
							end
						end else begin
							n_kw_cnt  = '0;
							n_flag    = 1'b1;
							do_normal = 1'b1;
						end
					end else begin
						do_normal = 1'b1;
					end
					if (do_normal) begin
						if (c == CH_DQUOTE) begin
							n_mode = MODE_DQUOTE;
						end else if (c == CH_SQUOTE) begin
							n_mode = MODE_SQUOTE;
						end else if (c == CH_SLASH) begin
							n_pending = 1'b1;
						end else if (first_hit.hit) begin
							n_kw_idx = first_hit.idx;
							n_kw_cnt = 3'd1;
						end else if (is_alnum(c)) begin
							n_flag = 1'b1;
						end
					end
				end
			endcase
			if (c == CH_NEWLINE) begin
				result.emit          = 1'b1;
				result.item.numbered = n_flag;
				n_flag      = 1'b0;
				n_has_bytes = 1'b0;
				n_count     = count_inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_NORMAL;
			pending_q   <= 1'b0;
			kw_idx_q    <= '0;
			kw_cnt_q    <= '0;
			bs_par_q    <= 1'b0;
			flag_q      <= 1'b0;
			has_bytes_q <= 1'b0;
			count_q     <= '0;
		end else if (step) begin
			mode_q      <= n_mode;
			pending_q   <= n_pending;
			kw_idx_q    <= n_kw_idx;
			kw_cnt_q    <= n_kw_cnt;
			bs_par_q    <= n_bs_par;
			flag_q      <= n_flag;
			has_bytes_q <= n_has_bytes;
			count_q     <= n_count;
		end
	end

	`ASSERT_PROP(a_pend_mode, clk, arst_n, pending_q |-> (mode_q == MODE_NORMAL || mode_q == MODE_BLOCK), "pending byte outside normal text or block comment")
	`ASSERT_PROP(a_kw_mode, clk, arst_n, (kw_cnt_q != '0) |-> (mode_q == MODE_NORMAL && !pending_q), "partial keyword outside normal text")
	`ASSERT_PROP(a_kw_len, clk, arst_n, (kw_cnt_q != '0) |-> (kw_cnt_q < KW_LEN[kw_idx_q]), "partial keyword longer than its keyword")
	`ASSERT_PROP(a_flush_clear, clk, arst_n, (step && item.kind) |=> (count_q == '0 && !has_bytes_q && kw_cnt_q == '0), "flush did not clear the scanner")

endmodule

FILE: design/c_source_line_classifier.sv
// ---------------------------------------------------------------------------
// c_source_line_classifier
// Scans C source text one byte per beat and reports, for each line, its number
// and whether it holds a letter or digit outside comments, quotes and
// skipped keywords.
//
//   channel  | direction | payload       | beat
//   ---------+-----------+---------------+------------------------------------
//   src      | in        | src_item_t    | one source byte or an end of input
//   res      | out       | res_item_t    | one completed line
//
// One byte is taken per cycle while the pipeline does not stall; a byte moves
// from the input register through the scanner into the result register.
// The scanner state advances only when the result register can take a line.
// A stalled result holds the pipeline once the input register is also full.
// Reset clears all lexer state and the line counter, as does an end of input.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module c_source_line_classifier import cslc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      src_valid,
	output logic      src_ready,
	input  src_item_t src_item,
	output logic      res_valid,
	input  logic      res_ready,
	output res_item_t res_item
);

	logic      valid_s1;
	src_item_t item_s1;
	logic      advance;
	logic      res_valid_q;
	res_item_t res_item_q;
	scan_out_t scan;

	assign advance   = valid_s1 && (!res_valid_q || res_ready);
	assign src_ready = !valid_s1 || advance;
	assign res_valid = res_valid_q;
	assign res_item  = res_item_q;

	cslc_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.result (scan)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (src_valid && src_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (src_valid && src_ready)
			item_s1 <= src_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && scan.emit) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && scan.emit)
			res_item_q <= scan.item;
	end

	`ASSERT_PROP(a_line_nonzero, clk, arst_n, res_valid_q |-> (res_item_q.line_num != '0), "result with line number zero")
	`ASSERT_PROP(a_ready_empty, clk, arst_n, !valid_s1 |-> src_ready, "input register empty but not ready")
	`ASSERT_PROP(a_res_from_s1, clk, arst_n, $rose(res_valid_q) |-> $past(valid_s1), "result appeared without a byte in the input register")

endmodule
